@@ src/pst_pkg.sv @@
// Shared types and constants for the periodic sensor timer table.
package pst_pkg;

   // Default sizes of the timer table.
   localparam int CHANNELS_DEF   = 16;
   localparam int COUNT_BITS_DEF = 32;

   // Fixed field widths of the request, response and register ports.
   localparam int FUNC_BITS   = 2;
   localparam int CHAN_BITS   = 4;
   localparam int PERIOD_BITS = 32;
   localparam int MASK_BITS   = 16;

   // Reset value of the present mask: every channel exists.
   localparam logic [MASK_BITS-1:0] PRESENT_RESET = 16'hFFFF;

   // Request function codes.
   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_TICK    = 2'd0,
      FUNC_ENABLE  = 2'd1,
      FUNC_DISABLE = 2'd2,
      FUNC_ACK     = 2'd3
   } pst_func_type;

   // Sequencer states.
   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_SWEEP = 1'b1
   } pst_state_type;

   // Control from the sequencer to the counter table.
   typedef struct packed {
      logic rd_en;
      logic cd_we;
      logic rl_we;
      logic cd_from_period;
   } pst_tbl_ctl_type;

endpackage

@@ src/periodic_sensor_timer_table.sv @@
// Top level of the periodic sensor timer table: command decode, sweep sequencer, flags.
//
//   Channel   Ports                                   Handshake
//   --------  --------------------------------------  ------------------------------
//   request   req_func, req_channel, req_period,      start high while busy is low
//             req_ack_mask
//   response  rsp_fired_mask, rsp_pending_mask,       rsp_strobe for one cycle
//             rsp_refresh_request, rsp_init_request,
//             rsp_accepted
//   register  csr_write_data (present mask)           csr_write_en, no wait
//
// Enable, disable and acknowledge requests leave busy low; the response strobes in the
// cycle after the request.
// A tick sweeps the countdown memory one entry a cycle through its single read port and
// holds busy for the whole sweep.
// Reset is synchronous and clears the flags at once; there is no clearing pass.
// The response cannot be stalled; each result is presented for exactly one cycle.
module periodic_sensor_timer_table #(
   parameter int CHANNELS   = pst_pkg::CHANNELS_DEF,
   parameter int COUNT_BITS = pst_pkg::COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [pst_pkg::FUNC_BITS-1:0]     req_func,
   input  logic [pst_pkg::CHAN_BITS-1:0]     req_channel,
   input  logic [pst_pkg::PERIOD_BITS-1:0]   req_period,
   input  logic [pst_pkg::MASK_BITS-1:0]     req_ack_mask,
   output logic                              rsp_strobe,
   output logic [pst_pkg::MASK_BITS-1:0]     rsp_fired_mask,
   output logic [pst_pkg::MASK_BITS-1:0]     rsp_pending_mask,
   output logic                              rsp_refresh_request,
   output logic                              rsp_init_request,
   output logic                              rsp_accepted,
   input  logic                              csr_write_en,
   input  logic [pst_pkg::MASK_BITS-1:0]     csr_write_data
);

   localparam int IdxW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int MaskW = pst_pkg::MASK_BITS;

   pst_pkg::pst_state_type   state_ff, state_in;
   pst_pkg::pst_func_type    func;
   pst_pkg::pst_tbl_ctl_type tbl_ctl;

   logic                 accept;
   logic                 tick_accept;
   logic                 last_proc;
   logic                 proc_en;
   logic                 ch_ok;
   logic                 ch_en;
   logic [5:0]           ch_ext;
   logic [5:0]           proc_ext;
   logic [MaskW-1:0]     ch_bit;
   logic [MaskW-1:0]     proc_bit;
   logic [MaskW-1:0]     fired_next;
   logic [IdxW-1:0]      rd_addr;
   logic [IdxW-1:0]      wr_addr;
   logic                 cnt_hit;

   logic [IdxW:0]        iss_ff, iss_in;
   logic                 proc_vld_ff, proc_vld_in;
   logic [IdxW-1:0]      proc_idx_ff, proc_idx_in;
   logic [MaskW-1:0]     fired_acc_ff, fired_acc_in;
   logic [MaskW-1:0]     enabled_ff, enabled_in;
   logic [MaskW-1:0]     init_ff, init_in;
   logic [MaskW-1:0]     pending_ff, pending_in;
   logic [MaskW-1:0]     present_ff, present_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [MaskW-1:0]     rsp_fired_ff, rsp_fired_in;
   logic [MaskW-1:0]     rsp_pending_ff, rsp_pending_in;
   logic                 rsp_init_ff, rsp_init_in;
   logic                 rsp_accepted_ff, rsp_accepted_in;

   // Request decode and channel lookups.
   always_comb begin
      func        = pst_pkg::pst_func_type'(req_func);
      accept      = start && !busy;
      tick_accept = accept && (func == pst_pkg::FUNC_TICK);
      ch_ext      = 6'(req_channel);
      ch_bit      = MaskW'(1) << req_channel;
      ch_ok       = (ch_ext < 6'(CHANNELS)) && present_ff[req_channel];
      ch_en       = enabled_ff[req_channel];
      proc_ext    = 6'(proc_idx_ff);
      proc_bit    = MaskW'(1) << proc_ext[3:0];
      proc_en     = proc_vld_ff && (proc_ext < 6'(MaskW)) && enabled_ff[proc_ext[3:0]];
      last_proc   = proc_vld_ff && (proc_idx_ff == IdxW'(CHANNELS - 1));
      fired_next  = fired_acc_ff | ((proc_en && cnt_hit) ? proc_bit : '0);
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pst_pkg::ST_IDLE: begin
            if (tick_accept) begin
               state_in = pst_pkg::ST_SWEEP;
            end
         end
         pst_pkg::ST_SWEEP: begin
            if (last_proc) begin
               state_in = pst_pkg::ST_IDLE;
            end
         end
         default: state_in = pst_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: busy flag and table port control.
   always_comb begin
      busy                   = 1'b0;
      tbl_ctl.rd_en          = 1'b0;
      tbl_ctl.cd_we          = 1'b0;
      tbl_ctl.rl_we          = 1'b0;
      tbl_ctl.cd_from_period = 1'b0;
      rd_addr                = '0;
      wr_addr                = proc_idx_ff;
      unique case (state_ff)
         pst_pkg::ST_IDLE: begin
            tbl_ctl.rd_en          = tick_accept;
            tbl_ctl.cd_from_period = 1'b1;
            tbl_ctl.rl_we          = accept && (func == pst_pkg::FUNC_ENABLE) && ch_ok;
            tbl_ctl.cd_we          = tbl_ctl.rl_we && !ch_en;
            wr_addr                = ch_ext[IdxW-1:0];
         end
         pst_pkg::ST_SWEEP: begin
            busy          = 1'b1;
            tbl_ctl.rd_en = (iss_ff < (IdxW + 1)'(CHANNELS));
            rd_addr       = iss_ff[IdxW-1:0];
            tbl_ctl.cd_we = proc_en;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   // Sweep counters, flag updates and the response register contents.
   always_comb begin
      iss_in          = iss_ff;
      proc_vld_in     = 1'b0;
      proc_idx_in     = proc_idx_ff;
      fired_acc_in    = fired_next;
      enabled_in      = enabled_ff;
      init_in         = init_ff;
      pending_in      = pending_ff;
      present_in      = csr_write_en ? csr_write_data : present_ff;
      rsp_strobe_in   = 1'b0;
      rsp_fired_in    = '0;
      rsp_init_in     = 1'b0;
      rsp_accepted_in = 1'b1;

      if (state_ff == pst_pkg::ST_IDLE) begin
         if (tick_accept) begin
            iss_in       = (IdxW + 1)'(1);
            proc_vld_in  = 1'b1;
            proc_idx_in  = '0;
            fired_acc_in = '0;
         end
      end else begin
         if (iss_ff < (IdxW + 1)'(CHANNELS)) begin
            proc_vld_in = 1'b1;
            proc_idx_in = iss_ff[IdxW-1:0];
            iss_in      = iss_ff + (IdxW + 1)'(1);
         end
      end

      // Commands other than a tick finish in the cycle they are accepted.
      if (accept && !tick_accept) begin
         rsp_strobe_in = 1'b1;
         unique case (func)
            pst_pkg::FUNC_ENABLE: begin
               if (!ch_ok) begin
                  rsp_accepted_in = 1'b0;
               end else if (!ch_en) begin
                  enabled_in  = enabled_ff | ch_bit;
                  init_in     = init_ff | ch_bit;
                  rsp_init_in = !init_ff[req_channel];
               end
            end
            pst_pkg::FUNC_DISABLE: begin
               if (!ch_ok) begin
                  rsp_accepted_in = 1'b0;
               end else begin
                  enabled_in = enabled_ff & ~ch_bit;
                  pending_in = pending_ff & ~ch_bit;
               end
            end
            pst_pkg::FUNC_ACK: begin
               pending_in = pending_ff & ~req_ack_mask;
            end
            default: begin
               rsp_accepted_in = 1'b1;
            end
         endcase
      end

      // The last entry of a sweep closes the tick.
      if (last_proc) begin
         rsp_strobe_in = 1'b1;
         rsp_fired_in  = fired_next;
         pending_in    = pending_ff | fired_next;
      end

      rsp_pending_in = pending_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pst_pkg::ST_IDLE;
         iss_ff        <= '0;
         proc_vld_ff   <= 1'b0;
         enabled_ff    <= '0;
         init_ff       <= '0;
         pending_ff    <= '0;
         present_ff    <= pst_pkg::PRESENT_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         iss_ff        <= iss_in;
         proc_vld_ff   <= proc_vld_in;
         enabled_ff    <= enabled_in;
         init_ff       <= init_in;
         pending_ff    <= pending_in;
         present_ff    <= present_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      proc_idx_ff     <= proc_idx_in;
      fired_acc_ff    <= fired_acc_in;
      rsp_fired_ff    <= rsp_fired_in;
      rsp_pending_ff  <= rsp_pending_in;
      rsp_init_ff     <= rsp_init_in;
      rsp_accepted_ff <= rsp_accepted_in;
   end

   // Countdown and reload storage.
   pst_table #(
      .DEPTH      (CHANNELS),
      .COUNT_BITS (COUNT_BITS),
      .ADDR_BITS  (IdxW)
   ) u_table (
      .clock    (clock),
      .ctl      (tbl_ctl),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .period   (req_period[COUNT_BITS-1:0]),
      .cnt_hit  (cnt_hit)
   );

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_fired_mask      = rsp_fired_ff;
   assign rsp_pending_mask    = rsp_pending_ff;
   assign rsp_refresh_request = (rsp_pending_ff != '0);
   assign rsp_init_request    = rsp_init_ff;
   assign rsp_accepted        = rsp_accepted_ff;

   // A command other than a tick answers in the very next cycle.
   a_cmd_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func != pst_pkg::FUNC_TICK) |=> rsp_strobe)
      else $error("command response missing");

   // Busy only rises after an accepted tick.
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_func == pst_pkg::FUNC_TICK))
      else $error("busy rose without a tick");

   // Every channel that fired is pending in the same response.
   a_fired_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_fired_mask & ~rsp_pending_mask) == '0))
      else $error("fired channel not pending");

   // An init request is only given for an accepted enable.
   a_init_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_init_request) |-> rsp_accepted)
      else $error("init request on refused command");

   // The countdown is written while idle only by an accepted enable.
   a_idle_write: assert property (@(posedge clock) disable iff (reset)
      (tbl_ctl.cd_we && !busy) |-> (accept && func == pst_pkg::FUNC_ENABLE))
      else $error("stray countdown write");

endmodule

@@ src/pst_table.sv @@
// Countdown and reload memories with the per-entry decrement and reload logic.
module pst_table #(
   parameter int DEPTH      = pst_pkg::CHANNELS_DEF,
   parameter int COUNT_BITS = pst_pkg::COUNT_BITS_DEF,
   parameter int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                          clock,
   input  pst_pkg::pst_tbl_ctl_type      ctl,
   input  logic [ADDR_BITS-1:0]          rd_addr,
   input  logic [ADDR_BITS-1:0]          wr_addr,
   input  logic [COUNT_BITS-1:0]         period,
   output logic                          cnt_hit
);

   logic [COUNT_BITS-1:0] cd_mem [DEPTH];
   logic [COUNT_BITS-1:0] rl_mem [DEPTH];
   logic [COUNT_BITS-1:0] cd_rd_ff;
   logic [COUNT_BITS-1:0] rl_rd_ff;
   logic [COUNT_BITS-1:0] cd_dec;
   logic [COUNT_BITS-1:0] cnt_next;
   logic [COUNT_BITS-1:0] cd_wdata;

   // Synchronous read port; the read data is registered.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         cd_rd_ff <= cd_mem[rd_addr];
         rl_rd_ff <= rl_mem[rd_addr];
      end
   end

   // Decrement modulo the counter width; a zero result reloads and fires.
   always_comb begin
      cd_dec   = cd_rd_ff - COUNT_BITS'(1);
      cnt_hit  = (cd_dec == '0);
      cnt_next = cnt_hit ? rl_rd_ff : cd_dec;
      cd_wdata = ctl.cd_from_period ? period : cnt_next;
   end

   // Sweeps write back the countdown; an enable loads the reload, both if off.
   always_ff @(posedge clock) begin
      if (ctl.cd_we) begin
         cd_mem[wr_addr] <= cd_wdata;
      end
      if (ctl.rl_we) begin
         rl_mem[wr_addr] <= period;
      end
   end

endmodule
